// ===== hw/rtl/bdnp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdnp_pkg
// shared constants for the bump normal perturbation pipeline
// ----------------------------------------------------------------------------
package bdnp_pkg;

  // fraction bits of unit vector components
  localparam int unsigned FracBits = 30;
  // width of lengths and unit magnitudes
  localparam int unsigned LenW = 31;
  // in-plane tangent run, 255 in q16.16
  localparam logic [23:0] TanRun = 24'hFF0000;
  localparam logic [15:0] ScaleReset = 16'd256;

  typedef struct packed {
    logic [7:0] n0;
    logic [7:0] n1;
    logic [7:0] n2;
    logic [7:0] alpha;
  } pix_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bdnp_isqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdnp_isqrt
// pipelined floor square root, one result bit per stage, n independent lanes
// ----------------------------------------------------------------------------
module bdnp_isqrt #(
  parameter int unsigned K  = 31,
  parameter int unsigned N  = 1,
  parameter int unsigned SW = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [N-1:0][2*K-1:0]     rad_i,
  input  logic [SW-1:0]             side_i,
  output logic                      valid_o,
  output logic [N-1:0][K-1:0]       root_o,
  output logic [SW-1:0]             side_o
);

  localparam int unsigned RW = 2 * K;

  logic [N-1:0][RW-1:0] v_q [K];
  logic [N-1:0][RW-1:0] v_d [K];
  logic [N-1:0][RW-1:0] r_q [K];
  logic [N-1:0][RW-1:0] r_d [K];
  logic [SW-1:0]        side_q [K];
  logic [K-1:0]         vld_q;

  always_comb begin : c_step
    logic [RW-1:0] vi;
    logic [RW-1:0] ri;
    logic [RW-1:0] sm;
    logic [RW-1:0] bt;
    for (int i = 0; i < K; i++) begin
      bt = RW'(1) << (2 * (K - 1 - i));
      for (int n = 0; n < N; n++) begin
        if (i == 0) begin
          vi = rad_i[n];
          ri = '0;
        end else begin
          vi = v_q[i-1][n];
          ri = r_q[i-1][n];
        end
        sm = ri + bt;
        if (vi >= sm) begin
          v_d[i][n] = vi - sm;
          r_d[i][n] = (ri >> 1) + bt;
        end else begin
          v_d[i][n] = vi;
          r_d[i][n] = ri >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[K-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q       <= v_d;
      r_q       <= r_d;
      side_q[0] <= side_i;
      for (int i = 1; i < K; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  always_comb begin
    for (int n = 0; n < N; n++) begin
      root_o[n] = r_q[K-1][n][K-1:0];
    end
  end

  assign valid_o = vld_q[K-1];
  assign side_o  = side_q[K-1];

endmodule
`default_nettype wire

// ===== hw/rtl/bdnp_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdnp_div
// pipelined restoring divider giving a * 2^frac / den for a <= den,
// one quotient bit per stage, n independent lanes
// ----------------------------------------------------------------------------
module bdnp_div #(
  parameter int unsigned DW = 31,
  parameter int unsigned N  = 1,
  parameter int unsigned SW = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [N-1:0][DW-1:0]  a_i,
  input  logic [N-1:0][DW-1:0]  den_i,
  input  logic [SW-1:0]         side_i,
  output logic                  valid_o,
  output logic [N-1:0][DW-1:0]  q_o,
  output logic [SW-1:0]         side_o
);
  import bdnp_pkg::*;

  localparam int unsigned QB = FracBits + 1;

  logic [N-1:0][DW-1:0] r_q [QB];
  logic [N-1:0][DW-1:0] r_d [QB];
  logic [N-1:0][DW-1:0] q_q [QB];
  logic [N-1:0][DW-1:0] q_d [QB];
  logic [N-1:0][DW-1:0] d_q [QB];
  logic [N-1:0][DW-1:0] d_d [QB];
  logic [SW-1:0]        side_q [QB];
  logic [QB-1:0]        vld_q;

  always_comb begin : c_step
    logic [DW:0]   rr;
    logic [DW:0]   df;
    logic [DW-1:0] di;
    logic [DW-1:0] qi;
    logic          ge;
    for (int i = 0; i < QB; i++) begin
      for (int n = 0; n < N; n++) begin
        if (i == 0) begin
          rr = {1'b0, a_i[n]};
          di = den_i[n];
          qi = '0;
        end else begin
          rr = {r_q[i-1][n], 1'b0};
          di = d_q[i-1][n];
          qi = q_q[i-1][n];
        end
        df = rr - {1'b0, di};
        ge = (rr >= {1'b0, di});
        r_d[i][n] = ge ? df[DW-1:0] : rr[DW-1:0];
        q_d[i][n] = {qi[DW-2:0], ge};
        d_d[i][n] = di;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QB-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q       <= r_d;
      q_q       <= q_d;
      d_q       <= d_d;
      side_q[0] <= side_i;
      for (int i = 1; i < QB; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign valid_o = vld_q[QB-1];
  assign q_o     = q_q[QB-1];
  assign side_o  = side_q[QB-1];

endmodule
`default_nettype wire

// ===== hw/rtl/detail_bump_normal_perturb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// detail_bump_normal_perturb
// perturbs a tangent-space normal by bump height slopes, one pixel per cycle
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  cfg      in   valid / ready      bump_scale, unsigned q8.8
//  in       in   valid / stall      normal rgba bytes, three q8.8 heights
//  out      out  valid / stall      perturbed normal rgb bytes, alpha
//
//  one pixel per cycle when not stalled; each pixel passes through two
//  square root and two divider chains of one bit per stage
//  reset clears valid bits and sets bump_scale to 1.0
//  the whole pipeline holds while the output register is full and stalled
// ----------------------------------------------------------------------------
module detail_bump_normal_perturb (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         normal_red_i,
  input  logic [7:0]         normal_green_i,
  input  logic [7:0]         normal_blue_i,
  input  logic [7:0]         normal_alpha_i,
  input  logic signed [15:0] bump_here_i,
  input  logic signed [15:0] bump_right_i,
  input  logic signed [15:0] bump_below_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_red_o,
  output logic [7:0]         out_green_o,
  output logic [7:0]         out_blue_o,
  output logic [7:0]         out_alpha_o
);
  import bdnp_pkg::*;

  typedef struct packed {
    logic [23:0] ppx;
    logic [29:0] ddx;
    logic [23:0] ppy;
    logic [29:0] ddy;
    logic        negx;
    logic        negy;
    pix_t        pix;
  } side1_t;

  typedef struct packed {
    logic negx;
    logic negy;
    pix_t pix;
  } side2_t;

  typedef struct packed {
    logic [LenW-1:0] tx0;
    logic [LenW-1:0] atx2;
    logic [LenW-1:0] ty1;
    logic [LenW-1:0] aty2;
    logic            negx;
    logic            negy;
  } tan_t;

  typedef struct packed {
    tan_t            tan;
    logic [LenW-1:0] m0;
    logic [LenW-1:0] m1;
    logic [LenW-1:0] m2;
    pix_t            pix;
  } side3_t;

  typedef struct packed {
    tan_t tan;
    logic zero;
    pix_t pix;
  } side4_t;

  function automatic logic [1:0] shamt(input logic [32:0] m);
    if (m[32]) begin
      shamt = 2'd3;
    end else if (m[31]) begin
      shamt = 2'd2;
    end else if (m[30]) begin
      shamt = 2'd1;
    end else begin
      shamt = 2'd0;
    end
  endfunction

  function automatic logic [61:0] rad2(input logic [23:0] pp, input logic [29:0] dd);
    logic [47:0] p2;
    logic [59:0] d2;
    p2 = pp * pp;
    d2 = dd * dd;
    rad2 = {14'b0, p2} + {2'b0, d2};
  endfunction

  function automatic logic [LenW-1:0] xmag(input logic [LenW-1:0] a,
                                           input logic [LenW-1:0] b);
    logic [61:0] pr;
    pr = {31'b0, a} * {31'b0, b};
    xmag = pr[60:30];
  endfunction

  function automatic logic [60:0] sq61(input logic [LenW-1:0] m);
    logic [61:0] pr;
    pr = {31'b0, m} * {31'b0, m};
    sq61 = pr[60:0];
  endfunction

  function automatic logic signed [31:0] sgn(input logic [LenW-1:0] m, input logic neg);
    logic [31:0] e;
    e = {1'b0, m};
    sgn = neg ? -e : e;
  endfunction

  function automatic logic signed [39:0] mul(input logic [7:0] n, input logic [31:0] t);
    logic signed [39:0] ne;
    logic signed [39:0] te;
    ne = {{32{n[7]}}, n};
    te = {{8{t[31]}}, t};
    mul = ne * te;
  endfunction

  function automatic logic [7:0] enc(input logic [40:0] s);
    logic signed [11:0] g;
    g = $signed({s[40], s[40:30]}) + 12'sd128;
    if (g < 12'sd0) begin
      enc = 8'd0;
    end else if (g > 12'sd255) begin
      enc = 8'd255;
    end else begin
      enc = g[7:0];
    end
  endfunction

  logic        en;
  logic [15:0] scale_q;

  // stage a: scaled heights
  logic        va_q;
  logic [31:0] ha_q, hb_q, hc_q;
  pix_t        pa_q;
  // stage b: slope magnitudes
  logic        vb_q;
  logic [32:0] mdx_q, mdy_q;
  logic        negx_b_q, negy_b_q;
  pix_t        pb_q;
  // stage c: normalizer inputs
  logic        vc_q;
  side1_t      sc_q;
  // stage d: squared lengths
  logic        vd_q;
  logic [61:0] radx_q, rady_q;
  side1_t      sd_q;

  logic                        s1_valid;
  logic [1:0][LenW-1:0]        s1_len;
  logic [$bits(side1_t)-1:0]   s1_side;
  side1_t                      s1;
  logic                        d1_valid;
  logic [3:0][LenW-1:0]        d1_q;
  logic [3:0][LenW-1:0]        d1_a;
  logic [3:0][LenW-1:0]        d1_den;
  logic [$bits(side2_t)-1:0]   d1_side;
  side2_t                      d1s;
  side2_t                      d1_in;

  // stage e/f/g: cross product and its squared length
  logic        ve_q, vf_q, vg_q;
  side3_t      se_q, sf_q, sg_q;
  logic [60:0] sq0_q, sq1_q, sq2_q;
  logic [61:0] crad_q;

  logic                        s2_valid;
  logic [0:0][LenW-1:0]        s2_len;
  logic [$bits(side3_t)-1:0]   s2_side;
  side3_t                      s2;
  logic                        d2_valid;
  logic [2:0][LenW-1:0]        d2_q;
  logic [2:0][LenW-1:0]        d2_a;
  logic [2:0][LenW-1:0]        d2_den;
  logic [$bits(side4_t)-1:0]   d2_side;
  side4_t                      d2s;
  side4_t                      d2_in;

  // stage h: signed matrix, stage i: products
  logic        vh_q, vi_q;
  logic [31:0] tx0_q, tx2_q, ty1_q, ty2_q, z0_q, z1_q, z2_q;
  logic [7:0]  n0h_q, n1h_q, n2h_q, alh_q;
  logic [39:0] p00_q, p20_q, p11_q, p21_q, p02_q, p12_q, p22_q;
  logic [7:0]  ali_q;

  logic        out_valid_q;
  logic [7:0]  out_red_q, out_green_q, out_blue_q, out_alpha_q;
  logic [40:0] s0, s1_sum, s2_sum;

  assign en          = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
    end else if (cfg_valid_i) begin
      scale_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      vd_q        <= 1'b0;
      ve_q        <= 1'b0;
      vf_q        <= 1'b0;
      vg_q        <= 1'b0;
      vh_q        <= 1'b0;
      vi_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      va_q        <= in_valid_i;
      vb_q        <= va_q;
      vc_q        <= vb_q;
      vd_q        <= vc_q;
      ve_q        <= d1_valid;
      vf_q        <= ve_q;
      vg_q        <= vf_q;
      vh_q        <= d2_valid;
      vi_q        <= vh_q;
      out_valid_q <= vi_q;
    end
  end

  always_ff @(posedge clk_i) begin : p_front
    logic [32:0] sc;
    logic [32:0] dx;
    logic [32:0] dy;
    logic [1:0]  shx;
    logic [1:0]  shy;
    sc = {17'b0, scale_q};
    dx = {hb_q[31], hb_q} - {ha_q[31], ha_q};
    dy = {hc_q[31], hc_q} - {ha_q[31], ha_q};
    shx = shamt(mdx_q);
    shy = shamt(mdy_q);
    if (en) begin
      ha_q     <= 32'({{17{bump_here_i[15]}}, bump_here_i} * sc);
      hb_q     <= 32'({{17{bump_right_i[15]}}, bump_right_i} * sc);
      hc_q     <= 32'({{17{bump_below_i[15]}}, bump_below_i} * sc);
      pa_q     <= '{n0: normal_red_i, n1: normal_green_i, n2: normal_blue_i,
                    alpha: normal_alpha_i};
      negx_b_q <= dx[32];
      negy_b_q <= dy[32];
      mdx_q    <= dx[32] ? (33'd0 - dx) : dx;
      mdy_q    <= dy[32] ? (33'd0 - dy) : dy;
      pb_q     <= pa_q;
      sc_q     <= '{ppx: TanRun >> shx, ddx: 30'(mdx_q >> shx),
                    ppy: TanRun >> shy, ddy: 30'(mdy_q >> shy),
                    negx: negx_b_q, negy: negy_b_q, pix: pb_q};
      radx_q   <= rad2(sc_q.ppx, sc_q.ddx);
      rady_q   <= rad2(sc_q.ppy, sc_q.ddy);
      sd_q     <= sc_q;
    end
  end

  bdnp_isqrt #(
    .K  (LenW),
    .N  (2),
    .SW ($bits(side1_t))
  ) u_tan_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vd_q),
    .rad_i   ({rady_q, radx_q}),
    .side_i  (sd_q),
    .valid_o (s1_valid),
    .root_o  (s1_len),
    .side_o  (s1_side)
  );

  assign s1        = side1_t'(s1_side);
  assign d1_a[0]   = LenW'(s1.ppx);
  assign d1_a[1]   = LenW'(s1.ddx);
  assign d1_a[2]   = LenW'(s1.ppy);
  assign d1_a[3]   = LenW'(s1.ddy);
  assign d1_den[0] = s1_len[0];
  assign d1_den[1] = s1_len[0];
  assign d1_den[2] = s1_len[1];
  assign d1_den[3] = s1_len[1];
  assign d1_in     = '{negx: s1.negx, negy: s1.negy, pix: s1.pix};

  bdnp_div #(
    .DW (LenW),
    .N  (4),
    .SW ($bits(side2_t))
  ) u_tan_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_valid),
    .a_i     (d1_a),
    .den_i   (d1_den),
    .side_i  (d1_in),
    .valid_o (d1_valid),
    .q_o     (d1_q),
    .side_o  (d1_side)
  );

  assign d1s = side2_t'(d1_side);

  always_ff @(posedge clk_i) begin
    if (en) begin
      se_q.tan <= '{tx0: d1_q[0], atx2: d1_q[1], ty1: d1_q[2], aty2: d1_q[3],
                    negx: d1s.negx, negy: d1s.negy};
      se_q.m0  <= xmag(d1_q[1], d1_q[2]);
      se_q.m1  <= xmag(d1_q[0], d1_q[3]);
      se_q.m2  <= xmag(d1_q[0], d1_q[2]);
      se_q.pix <= d1s.pix;
      sq0_q    <= sq61(se_q.m0);
      sq1_q    <= sq61(se_q.m1);
      sq2_q    <= sq61(se_q.m2);
      sf_q     <= se_q;
      crad_q   <= {1'b0, sq0_q} + {1'b0, sq1_q} + {1'b0, sq2_q};
      sg_q     <= sf_q;
    end
  end

  bdnp_isqrt #(
    .K  (LenW),
    .N  (1),
    .SW ($bits(side3_t))
  ) u_crs_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vg_q),
    .rad_i   (crad_q),
    .side_i  (sg_q),
    .valid_o (s2_valid),
    .root_o  (s2_len),
    .side_o  (s2_side)
  );

  assign s2        = side3_t'(s2_side);
  assign d2_a[0]   = s2.m0;
  assign d2_a[1]   = s2.m1;
  assign d2_a[2]   = s2.m2;
  assign d2_den[0] = s2_len[0];
  assign d2_den[1] = s2_len[0];
  assign d2_den[2] = s2_len[0];
  assign d2_in     = '{tan: s2.tan, zero: (s2_len[0] == '0), pix: s2.pix};

  bdnp_div #(
    .DW (LenW),
    .N  (3),
    .SW ($bits(side4_t))
  ) u_crs_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_valid),
    .a_i     (d2_a),
    .den_i   (d2_den),
    .side_i  (d2_in),
    .valid_o (d2_valid),
    .q_o     (d2_q),
    .side_o  (d2_side)
  );

  assign d2s    = side4_t'(d2_side);
  assign s0     = {p00_q[39], p00_q} + {p20_q[39], p20_q};
  assign s1_sum = {p11_q[39], p11_q} + {p21_q[39], p21_q};
  assign s2_sum = {p02_q[39], p02_q} + {p12_q[39], p12_q} + {p22_q[39], p22_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      tx0_q       <= {1'b0, d2s.tan.tx0};
      tx2_q       <= sgn(d2s.tan.atx2, d2s.tan.negx);
      ty1_q       <= {1'b0, d2s.tan.ty1};
      ty2_q       <= sgn(d2s.tan.aty2, d2s.tan.negy);
      z0_q        <= d2s.zero ? '0 : sgn(d2_q[0], !d2s.tan.negx);
      z1_q        <= d2s.zero ? '0 : sgn(d2_q[1], !d2s.tan.negy);
      z2_q        <= d2s.zero ? '0 : {1'b0, d2_q[2]};
      n0h_q       <= {~d2s.pix.n0[7], d2s.pix.n0[6:0]};
      n1h_q       <= {~d2s.pix.n1[7], d2s.pix.n1[6:0]};
      n2h_q       <= {~d2s.pix.n2[7], d2s.pix.n2[6:0]};
      alh_q       <= d2s.pix.alpha;
      p00_q       <= mul(n0h_q, tx0_q);
      p20_q       <= mul(n2h_q, z0_q);
      p11_q       <= mul(n1h_q, ty1_q);
      p21_q       <= mul(n2h_q, z1_q);
      p02_q       <= mul(n0h_q, tx2_q);
      p12_q       <= mul(n1h_q, ty2_q);
      p22_q       <= mul(n2h_q, z2_q);
      ali_q       <= alh_q;
      out_red_q   <= enc(s0);
      out_green_q <= enc(s1_sum);
      out_blue_q  <= enc(s2_sum);
      out_alpha_q <= ali_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_red_q;
  assign out_green_o = out_green_q;
  assign out_blue_o  = out_blue_q;
  assign out_alpha_o = out_alpha_q;

endmodule
`default_nettype wire

// ===== dv/detail_bump_normal_perturb_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// detail_bump_normal_perturb_tb
// drives pixels with normals and bump heights through the perturbation
// pipeline under random idling and stalls, predicts each perturbed normal
// in fixed point and checks every output transaction field by field
// ----------------------------------------------------------------------------
module detail_bump_normal_perturb_tb;
  import bdnp_pkg::*;

  localparam int unsigned PipeLat = 134;
  localparam longint unsigned Q30One = 64'd1 << 30;
  localparam int unsigned CycleLimit = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [7:0] normal_red_i = '0, normal_green_i = '0, normal_blue_i = '0;
  logic [7:0] normal_alpha_i = '0;
  logic signed [15:0] bump_here_i = '0, bump_right_i = '0, bump_below_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] out_red_o, out_green_o, out_blue_o, out_alpha_o;

  detail_bump_normal_perturb u_top (.*);

  logic [15:0] scale_q = ScaleReset;
  pix_t expected_px[$];
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit idle_en = 1'b1;
  int unsigned hold_req = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("** detail_bump_normal_perturb: FAILED **");
      $finish;
    end
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned magn(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint signed_of(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic void tangent(longint d, output longint run_n, output longint slope_n);
    longint unsigned md, pp, dd, len;
    int unsigned s;
    md = magn(d);
    s = 0;
    while ((md >> s) >= Q30One) s++;
    pp = 64'(TanRun) >> s;
    dd = md >> s;
    len = isqrt(pp * pp + dd * dd);
    if (len == 0) begin
      run_n = 0;
      slope_n = 0;
    end else begin
      run_n = longint'((pp << 30) / len);
      slope_n = signed_of((dd << 30) / len, d < 0);
    end
  endfunction

  function automatic logic [7:0] to_byte(longint s);
    longint f;
    f = (s >>> 30) + 128;
    if (f < 0) f = 0;
    if (f > 255) f = 255;
    return f[7:0];
  endfunction

  function automatic pix_t perturb(pix_t p, logic signed [15:0] a, logic signed [15:0] b,
                                   logic signed [15:0] c, logic [15:0] sc);
    longint n0, n1, n2, ha, hb, hc, tx0, tx2, ty1, ty2, c0, c1, c2, z0, z1, z2;
    longint unsigned m0, m1, m2, clen;
    pix_t r;
    n0 = longint'(p.n0) - 128;
    n1 = longint'(p.n1) - 128;
    n2 = longint'(p.n2) - 128;
    ha = longint'(a) * longint'(sc);
    hb = longint'(b) * longint'(sc);
    hc = longint'(c) * longint'(sc);
    tangent(hb - ha, tx0, tx2);
    tangent(hc - ha, ty1, ty2);
    c0 = signed_of(magn(-(tx2 * ty1)) >> 30, -(tx2 * ty1) < 0);
    c1 = signed_of(magn(-(tx0 * ty2)) >> 30, -(tx0 * ty2) < 0);
    c2 = signed_of(magn(tx0 * ty1) >> 30, (tx0 * ty1) < 0);
    m0 = magn(c0);
    m1 = magn(c1);
    m2 = magn(c2);
    clen = isqrt(m0 * m0 + m1 * m1 + m2 * m2);
    z0 = 0;
    z1 = 0;
    z2 = 0;
    if (clen != 0) begin
      z0 = signed_of((m0 << 30) / clen, c0 < 0);
      z1 = signed_of((m1 << 30) / clen, c1 < 0);
      z2 = signed_of((m2 << 30) / clen, c2 < 0);
    end
    r.n0 = to_byte(n0 * tx0 + n2 * z0);
    r.n1 = to_byte(n1 * ty1 + n2 * z1);
    r.n2 = to_byte(n0 * tx2 + n1 * ty2 + n2 * z2);
    r.alpha = p.alpha;
    return r;
  endfunction

  // receiver: random stall bursts, plus long hold-offs on request
  initial begin
    int unsigned burst;
    burst = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        out_stall_i <= 1'b1;
        hold_req = hold_req - 1;
      end else if (burst > 0) begin
        out_stall_i <= 1'b1;
        burst--;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        burst = $urandom_range(0, 5);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    pix_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_px.size() == 0) begin
        $display("%0t: unexpected transaction r=%0d g=%0d b=%0d a=%0d", $time,
                 out_red_o, out_green_o, out_blue_o, out_alpha_o);
        fail_cnt++;
      end else begin
        want = expected_px.pop_front();
        if (out_red_o !== want.n0) begin
          $display("%0t: out_red expected %0d actual %0d", $time, want.n0, out_red_o);
          fail_cnt++;
        end
        if (out_green_o !== want.n1) begin
          $display("%0t: out_green expected %0d actual %0d", $time, want.n1, out_green_o);
          fail_cnt++;
        end
        if (out_blue_o !== want.n2) begin
          $display("%0t: out_blue expected %0d actual %0d", $time, want.n2, out_blue_o);
          fail_cnt++;
        end
        if (out_alpha_o !== want.alpha) begin
          $display("%0t: out_alpha expected %0d actual %0d", $time, want.alpha, out_alpha_o);
          fail_cnt++;
        end
      end
    end
  end

  // one pixel transaction; valid stays high unless a gap is taken
  task automatic send_pixel(pix_t p, logic signed [15:0] a, logic signed [15:0] b,
                            logic signed [15:0] c);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    {normal_red_i, normal_green_i, normal_blue_i, normal_alpha_i} <= p;
    bump_here_i <= a;
    bump_right_i <= b;
    bump_below_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    expected_px.push_back(perturb(p, a, b, c, scale_q));
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (expected_px.size() == 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_scale(logic [15:0] v);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    scale_q = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic pix_t rand_pix();
    return pix_t'($urandom);
  endfunction

  task automatic send_random(int unsigned n);
    logic signed [15:0] a, b, c;
    repeat (n) begin
      a = 16'($urandom);
      if ($urandom_range(0, 1)) begin
        b = a + $signed(16'($urandom_range(0, 1023) - 512));
        c = a + $signed(16'($urandom_range(0, 1023) - 512));
      end else begin
        b = 16'($urandom);
        c = 16'($urandom);
      end
      send_pixel(rand_pix(), a, b, c);
    end
  endtask

  task automatic test_directed();
    pix_t p;
    logic [15:0] scales[3] = '{16'd256, 16'd0, 16'hFFFF};
    foreach (scales[i]) begin
      set_scale(scales[i]);
      send_pixel('{8'd128, 8'd128, 8'd255, 8'd0}, 16'sd0, 16'sd0, 16'sd0);
      send_pixel('{8'd0, 8'd0, 8'd0, 8'd255}, -16'sd32768, 16'sd32767, 16'sd32767);
      send_pixel('{8'd255, 8'd255, 8'd255, 8'd170}, 16'sd32767, -16'sd32768, -16'sd32768);
      send_pixel('{8'd255, 8'd0, 8'd128, 8'd85}, 16'sd100, 16'sd356, -16'sd156);
      p = '{8'd0, 8'd255, 8'd0, 8'd1};
      send_pixel(p, -16'sd32768, -16'sd32768, 16'sd32767);
      send_pixel('{8'd128, 8'd0, 8'd255, 8'd254}, 16'sd32767, 16'sd32767, -16'sd32768);
    end
  endtask

  task automatic test_random();
    logic [15:0] scales[4] = '{16'd1, 16'h0100, 16'h8000, 16'hFFFF};
    foreach (scales[i]) begin
      set_scale(scales[i]);
      send_random(100);
    end
    repeat (3) begin
      set_scale(16'($urandom));
      send_random(100);
    end
  endtask

  task automatic test_backpressure();
    set_scale(16'($urandom_range(0, 1023)));
    hold_req = 400;
    send_random(200);
    drain();
  endtask

  task automatic test_streaming();
    set_scale(ScaleReset);
    idle_en = 1'b0;
    send_random(150);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random();
    test_backpressure();
    test_streaming();
    drain();
    repeat (PipeLat + 20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("** detail_bump_normal_perturb: PASSED **");
    end else begin
      $display("** detail_bump_normal_perturb: FAILED **");
    end
    $finish;
  end
endmodule
